[sv/ugti_pkg.sv]
// Shared types and constants for the uniform grid table interpolator.
// No dependencies; imported by the top level and the checker.
package ugti_pkg;

  // Item kinds carried by the action field
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    RS_INTERP = 2'd0,
    RS_BELOW  = 2'd1,
    RS_ABOVE  = 2'd2
  } range_status_t;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_ENERGY_LOW    = 2'd0,
    REG_ENERGY_HIGH   = 2'd1,
    REG_INVERSE_STEP  = 2'd2,
    REG_POINTS_IN_USE = 2'd3
  } reg_index_t;

  localparam int          CFG_AW         = 4;
  localparam logic [31:0] RST_ENERGY_LOW = 32'd0;
  localparam logic [31:0] RST_ENERGY_HI  = 32'd0;
  localparam logic [31:0] RST_INV_STEP   = 32'h0001_0000;
  localparam logic [10:0] RST_POINTS     = 11'd1024;

  localparam logic [16:0] Q16_ONE   = 17'h1_0000;
  localparam logic [48:0] Q16_ROUND = 49'h0_0000_8000;

endpackage

[sv/ugti_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No package dependencies.
module ugti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

[sv/uniform_grid_table_interpolator.sv]
// Uniform grid table interpolator: one request per cycle sustained while the result
// channel does not back-pressure, loads and queries mixed freely.
// Stages: input reg, range compare/subtract, 32x32 multiply, table read (two read
// ports), blend products, round/output reg. Loads write the table at the read stage.
// Synchronous active-low reset clears pipeline valids and the config registers;
// table contents are not reset.
module uniform_grid_table_interpolator
  import ugti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [9:0]        in_entry_index,
  input  logic [31:0]       in_sample_value,
  input  logic [31:0]       in_energy,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_value,
  output logic [1:0]        out_range_status,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // ---------------- config registers ----------------
  logic [31:0] energy_low_r, energy_high_r, inverse_step_r;
  logic [10:0] points_r;
  reg_index_t  cfg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_index_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_low_r   <= RST_ENERGY_LOW;
      energy_high_r  <= RST_ENERGY_HI;
      inverse_step_r <= RST_INV_STEP;
      points_r       <= RST_POINTS;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENERGY_LOW:    energy_low_r   <= pwdata;
        REG_ENERGY_HIGH:   energy_high_r  <= pwdata;
        REG_INVERSE_STEP:  inverse_step_r <= pwdata;
        REG_POINTS_IN_USE: points_r       <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENERGY_LOW:    prdata = energy_low_r;
      REG_ENERGY_HIGH:   prdata = energy_high_r;
      REG_INVERSE_STEP:  prdata = inverse_step_r;
      REG_POINTS_IN_USE: prdata = {21'd0, points_r};
      default:           prdata = 32'd0;
    endcase
  end

  // last usable entry: points clamped to [2, TABLE_DEPTH], minus one
  logic [31:0] pts_clamp;
  logic [AW-1:0] last_idx;

  always_comb begin
    pts_clamp = {21'd0, points_r};
    if (pts_clamp < 32'd2) begin
      pts_clamp = 32'd2;
    end
    if (pts_clamp > 32'(TABLE_DEPTH)) begin
      pts_clamp = 32'(TABLE_DEPTH);
    end
  end

  assign last_idx = AW'(pts_clamp - 32'd1);

  // ---------------- stage ready chain ----------------
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, out_vld_r;

  assign rdy6     = !out_vld_r || out_ready;
  assign rdy5     = !s5_vld_r || rdy6;
  assign rdy4     = !s4_vld_r || rdy5;
  assign rdy3     = !s3_vld_r || rdy4;
  assign rdy2     = !s2_vld_r || rdy3;
  assign rdy1     = !s1_vld_r || rdy2;
  assign in_ready = rdy1;

  // ---------------- stage 1: request register ----------------
  logic        s1_act_r;
  logic [9:0]  s1_idx_r;
  logic [31:0] s1_sample_r, s1_energy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (rdy1) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_act_r    <= in_action;
      s1_idx_r    <= in_entry_index;
      s1_sample_r <= in_sample_value;
      s1_energy_r <= in_energy;
    end
  end

  // ---------------- stage 2: range test and offset ----------------
  logic        s2_act_r, s2_below_r, s2_above_r;
  logic [9:0]  s2_idx_r;
  logic [31:0] s2_sample_r, s2_diff_r;
  logic        s2_below_nxt, s2_above_nxt;

  assign s2_below_nxt = s1_energy_r < energy_low_r;
  assign s2_above_nxt = !s2_below_nxt && (s1_energy_r > energy_high_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (rdy2) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_act_r    <= s1_act_r;
      s2_idx_r    <= s1_idx_r;
      s2_sample_r <= s1_sample_r;
      s2_below_r  <= s2_below_nxt;
      s2_above_r  <= s2_above_nxt;
      s2_diff_r   <= s1_energy_r - energy_low_r;
    end
  end

  // ---------------- stage 3: position multiply ----------------
  logic        s3_act_r, s3_below_r, s3_above_r;
  logic [9:0]  s3_idx_r;
  logic [31:0] s3_sample_r;
  logic [47:0] s3_pos_r;
  logic [63:0] prod_nxt;

  assign prod_nxt = {32'd0, s2_diff_r} * {32'd0, inverse_step_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (rdy3) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_act_r    <= s2_act_r;
      s3_idx_r    <= s2_idx_r;
      s3_sample_r <= s2_sample_r;
      s3_below_r  <= s2_below_r;
      s3_above_r  <= s2_above_r;
      s3_pos_r    <= prod_nxt[63:16];
    end
  end

  // ---------------- stage 4: table access ----------------
  logic [31:0]   grid_idx;
  logic [AW-1:0] rd_lo, rd_hi;
  logic [15:0]   frac_nxt;
  range_status_t status_nxt;
  logic          tbl_we;
  logic [31:0]   ent_a, ent_b;

  assign grid_idx = s3_pos_r[47:16];

  always_comb begin
    rd_lo      = grid_idx[AW-1:0];
    rd_hi      = grid_idx[AW-1:0] + AW'(1);
    frac_nxt   = s3_pos_r[15:0];
    status_nxt = RS_INTERP;
    if (s3_below_r) begin
      rd_lo      = '0;
      rd_hi      = '0;
      frac_nxt   = 16'd0;
      status_nxt = RS_BELOW;
    end else if (s3_above_r) begin
      rd_lo      = last_idx;
      rd_hi      = last_idx;
      frac_nxt   = 16'd0;
      status_nxt = RS_ABOVE;
    end else if (grid_idx >= {{(32-AW){1'b0}}, last_idx}) begin
      // past the end: both neighbors are the last entry
      rd_lo = last_idx;
      rd_hi = last_idx;
    end
  end

  // loads commit here so they stay ordered with the reads of later queries
  assign tbl_we = rdy4 && s3_vld_r && (s3_act_r == ACT_LOAD)
                  && ({22'd0, s3_idx_r} < 32'(TABLE_DEPTH));

  ugti_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (AW'(s3_idx_r)),
    .wdata   (s3_sample_r),
    .re      (rdy4),
    .raddr_a (rd_lo),
    .raddr_b (rd_hi),
    .rdata_a (ent_a),
    .rdata_b (ent_b)
  );

  logic [15:0]   s4_frac_r;
  range_status_t s4_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (rdy4) begin
      s4_vld_r <= s3_vld_r && (s3_act_r == ACT_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_frac_r   <= frac_nxt;
      s4_status_r <= status_nxt;
    end
  end

  // ---------------- stage 5: blend products ----------------
  logic [16:0]   w_lo;
  logic [48:0]   s5_pa_r, s5_pb_r;
  range_status_t s5_status_r;

  assign w_lo = Q16_ONE - {1'b0, s4_frac_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (rdy5) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_pa_r     <= {17'd0, ent_a} * {32'd0, w_lo};
      s5_pb_r     <= {17'd0, ent_b} * {33'd0, s4_frac_r};
      s5_status_r <= s4_status_r;
    end
  end

  // ---------------- stage 6: round and output register ----------------
  logic [48:0]   sum_nxt;
  logic [31:0]   out_value_r;
  range_status_t out_status_r;

  assign sum_nxt = s5_pa_r + s5_pb_r + Q16_ROUND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rdy6) begin
      out_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      out_value_r  <= sum_nxt[47:16];
      out_status_r <= s5_status_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_value        = out_value_r;
  assign out_range_status = out_status_r;

endmodule

[sv/ugti_checker.sv]
// Port-level checks for the uniform grid table interpolator, bound to the top level.
// Imports ugti_pkg; no item of the package is used by the checks.
module ugti_checker
  import ugti_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic [1:0]  out_range_status,
  input logic        pready
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_range_status))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // with the sink ready, no stage can be blocked
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("request stalled while sink ready");

  // config port never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("config port wait state");

endmodule

bind uniform_grid_table_interpolator ugti_checker u_ugti_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_value        (out_value),
  .out_range_status (out_range_status),
  .pready           (pready)
);
